// ----- sv/skc_pkg.sv -----
`default_nettype none

package skc_pkg;

  // Container geometry
  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int HALF_COUNT   = (CAPACITY + 1) / 2;

  // Request opcodes; OP_NONE is accepted and ignored
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_IN_RD,
    S_IN_CMP,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  // One write and one read per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- sv/sorted_key_container_top.sv -----
// Operation: each entry touched is read, then compared or moved. Lookup compares from the top
//   entry down; insert moves larger-or-equal keys up; remove compares from slot 0, then moves
//   the entries above down. Refused, empty or unused requests go straight to the result.
// Throughput: one request at a time; the next is taken in the cycle after the result enters
//   the output register, which may still be waiting on out_ready.
// Reset: clears sequencer, count and out_valid; stored entries are never read above count.
`default_nettype none

module sorted_key_container_top
  import skc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] key,
  input  wire logic [31:0] payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [5:0]       index,
  output logic [31:0]      found_key,
  output logic [31:0]      found_payload,
  output logic [6:0]       entry_count,
  output logic             full_res,
  output logic             below_half
);

  state_t                  state, state_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  status_t                 res_status, res_status_next;
  logic [IDX_W-1:0]        res_index, res_index_next;
  logic [KEY_BITS-1:0]     res_fkey, res_fkey_next;
  logic [PAYLOAD_BITS-1:0] res_fpay, res_fpay_next;
  mem_req_t                mem_req;
  entry_t                  rd_data;
  entry_t                  new_entry;
  logic                    cmp_lt, cmp_eq;
  logic [CNT_W-1:0]        idx_ext, idx_inc;
  logic                    out_load;
  op_t                     op_in;

  skc_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Shared key comparator against the entry just read
  assign cmp_lt = key_r < rd_data.key;
  assign cmp_eq = key_r == rd_data.key;

  assign idx_ext   = CNT_W'(idx);
  assign idx_inc   = idx_ext + CNT_W'(1);
  assign new_entry = '{key: key_r, pay: pay_r};
  assign op_in     = op_t'(opcode);
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Sequencer: next state, working registers, store request
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_fkey_next   = res_fkey;
    res_fpay_next   = res_fpay;
    mem_req.we      = 1'b0;
    mem_req.wr_addr = idx;
    mem_req.wr_data = rd_data;
    mem_req.rd_addr = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_OK;
          res_index_next  = '0;
          res_fkey_next   = '0;
          res_fpay_next   = '0;
          case (op_in)
            OP_LOOKUP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                idx_next   = IDX_W'(count - CNT_W'(1));
                state_next = S_LK_RD;
              end
            end
            OP_INSERT: begin
              if (count >= CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else begin
                idx_next   = IDX_W'(count);
                state_next = S_IN_RD;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_ABSENT;
                state_next      = S_DONE;
              end else begin
                idx_next   = '0;
                state_next = S_RM_RD;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      // Floor lookup: walk down from the top entry
      S_LK_RD: begin
        mem_req.rd_addr = idx;
        state_next      = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (idx != '0 && cmp_lt) begin
          idx_next   = idx - IDX_W'(1);
          state_next = S_LK_RD;
        end else begin
          res_index_next = idx;
          res_fkey_next  = rd_data.key;
          res_fpay_next  = rd_data.pay;
          state_next     = S_DONE;
        end
      end
      // Insert: move larger-or-equal keys up one slot
      S_IN_RD: begin
        if (idx == '0) begin
          mem_req.we      = 1'b1;
          mem_req.wr_addr = idx;
          mem_req.wr_data = new_entry;
          count_next      = count + CNT_W'(1);
          res_index_next  = idx;
          state_next      = S_DONE;
        end else begin
          mem_req.rd_addr = idx - IDX_W'(1);
          state_next      = S_IN_CMP;
        end
      end
      S_IN_CMP: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = idx;
        if (cmp_lt || cmp_eq) begin
          mem_req.wr_data = rd_data;
          idx_next        = idx - IDX_W'(1);
          state_next      = S_IN_RD;
        end else begin
          mem_req.wr_data = new_entry;
          count_next      = count + CNT_W'(1);
          res_index_next  = idx;
          state_next      = S_DONE;
        end
      end
      // Remove: find first equal key
      S_RM_RD: begin
        mem_req.rd_addr = idx;
        state_next      = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (cmp_eq) begin
          res_index_next = idx;
          state_next     = S_SH_RD;
        end else if (idx_inc == count) begin
          res_status_next = ST_ABSENT;
          state_next      = S_DONE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_RM_RD;
        end
      end
      // Close the gap: move entries above down one slot
      S_SH_RD: begin
        if (idx_inc >= count) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          mem_req.rd_addr = IDX_W'(idx_inc);
          state_next      = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = idx;
        mem_req.wr_data = rd_data;
        idx_next        = idx + IDX_W'(1);
        state_next      = S_SH_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_fkey   <= res_fkey_next;
    res_fpay   <= res_fpay_next;
    if (state == S_IDLE && in_valid) begin
      key_r <= key;
      pay_r <= PAYLOAD_BITS'(payload);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      index         <= 6'(res_index);
      found_key     <= res_fkey;
      found_payload <= 32'(res_fpay);
      entry_count   <= 7'(count);
      full_res      <= (count == CNT_W'(CAPACITY));
      below_half    <= (count < CNT_W'(HALF_COUNT));
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_IN_RD || state == S_IN_CMP || state == S_SH_WR))
    else $error("store write outside insert or shift");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("insert refused while not full");

endmodule

`default_nettype wire

// ----- sv/skc_store.sv -----
`default_nettype none

module skc_store
  import skc_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  // Entry array, contents undefined until written
  entry_t mem [CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

`default_nettype wire

// ----- tb/sorted_key_container_checker.sv -----
// Watches both channels of the sorted key container, keeps a shadow copy of
// the container contents and compares every result request with the outcome
// that the shadow computes for the oldest outstanding request.
module sorted_key_container_checker
  import skc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] payload,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [5:0]  index,
  input  logic [31:0] found_key,
  input  logic [31:0] found_payload,
  input  logic [6:0]  entry_count,
  input  logic        full_res,
  input  logic        below_half,
  output int          fail_count,
  output int          waiting,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                 st;
    logic [IDX_W-1:0]        idx;
    logic [KEY_BITS-1:0]     fkey;
    logic [31:0]             fpay;
    logic [CNT_W-1:0]        cnt;
    logic                    full;
    logic                    half;
  } outcome_t;

  // Shadow container: sorted keys, payloads and fill level
  logic [KEY_BITS-1:0]     shadow_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] shadow_pay [CAPACITY];
  int                      held;

  // Outcomes of accepted requests, oldest first
  outcome_t outcome_q[$];

  // Applies one request to the shadow container and returns its outcome
  function automatic outcome_t container_apply(op_t op, logic [31:0] k, logic [31:0] p);
    outcome_t r;
    int       i;
    int       hit;
    r    = '0;
    r.st = ST_OK;
    hit  = -1;
    case (op)
      OP_LOOKUP: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // floor search from the top; falls back to slot 0
          i = held - 1;
          while (i > 0 && k < shadow_key[i]) i--;
          r.idx  = i[IDX_W-1:0];
          r.fkey = shadow_key[i];
          r.fpay = shadow_pay[i][31:0];
        end
      end
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          // new entry goes ahead of equal keys
          i = held;
          while (i > 0 && k <= shadow_key[i-1]) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_pay[i] = shadow_pay[i-1];
            i--;
          end
          shadow_key[i] = k;
          shadow_pay[i] = p;
          held++;
          r.idx = i[IDX_W-1:0];
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < held; i++)
          if (hit < 0 && shadow_key[i] == k) hit = i;
        if (hit < 0) begin
          r.st = ST_ABSENT;
        end else begin
          r.idx = hit[IDX_W-1:0];
          for (i = hit; i + 1 < held; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_pay[i] = shadow_pay[i+1];
          end
          held--;
        end
      end
      default: ;
    endcase
    r.cnt  = held[CNT_W-1:0];
    r.full = (held == CAPACITY);
    r.half = (held < HALF_COUNT);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare leaving results first, then book the request taken at this edge
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      held = 0;
      outcome_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with no request outstanding (status %0h, index %0d)",
                   $time, status, index);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 32'(want.st), 32'(status));
          check_field("index", 32'(want.idx), 32'(index));
          check_field("found_key", want.fkey, found_key);
          check_field("found_payload", want.fpay, found_payload);
          check_field("entry_count", 32'(want.cnt), 32'(entry_count));
          check_field("full_res", 32'(want.full), 32'(full_res));
          check_field("below_half", 32'(want.half), 32'(below_half));
        end
      end
      if (in_valid && in_ready)
        outcome_q.push_back(container_apply(op_t'(opcode), key, payload));
    end
    waiting <= outcome_q.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import skc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SEG_ITEMS    = 100;
  localparam int TAIL_CYCLES  = 2 * CAPACITY + 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_NONE;
  logic [31:0] key = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  index;
  logic [31:0] found_key;
  logic [31:0] found_payload;
  logic [6:0]  entry_count;
  logic        full_res;
  logic        below_half;

  int fail_count;
  int waiting;
  int checked;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int n_lookup = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_none = 0;

  // keys sent for insert, used to aim removes and lookups at live entries
  logic [31:0] key_log[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_key_container_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .key(key), .payload(payload),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .index(index), .found_key(found_key),
    .found_payload(found_payload), .entry_count(entry_count),
    .full_res(full_res), .below_half(below_half)
  );

  sorted_key_container_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .key(key), .payload(payload),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .index(index), .found_key(found_key),
    .found_payload(found_payload), .entry_count(entry_count),
    .full_res(full_res), .below_half(below_half),
    .fail_count(fail_count), .waiting(waiting), .checked(checked)
  );

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // One request, with random idle cycles ahead of it
  task automatic issue_request(input op_t op, input logic [31:0] k, input logic [31:0] p);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    payload  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_LOOKUP: n_lookup++;
      OP_INSERT: n_insert++;
      OP_REMOVE: n_remove++;
      default:   n_none++;
    endcase
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Small keys and extremes in over half the picks, so equal keys and hits are common
  function automatic logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return $urandom_range(15);
    if (roll < 55) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int          seg;
    int          sent;
    int          pos;
    int unsigned roll;
    bit          filling;
    op_t         op;
    logic [31:0] k;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty container, extremes, equal keys, floor fallback
    issue_request(OP_LOOKUP, 32'h0, 32'h0);
    issue_request(OP_REMOVE, 32'd5, 32'h0);
    issue_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'h0, 32'h0);
    issue_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'd100, 32'hAAAA_5555);
    issue_request(OP_INSERT, 32'd100, 32'h5555_AAAA);
    issue_request(OP_INSERT, 32'd100, 32'h1234_5678);
    issue_request(OP_LOOKUP, 32'd100, 32'h0);
    issue_request(OP_LOOKUP, 32'd99, 32'h0);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_LOOKUP, 32'h0, 32'h0);
    issue_request(OP_REMOVE, 32'd100, 32'h0);
    issue_request(OP_REMOVE, 32'd7, 32'h0);
    issue_request(OP_REMOVE, 32'h0, 32'h0);
    issue_request(OP_LOOKUP, 32'd50, 32'h0);
    issue_request(OP_LOOKUP, 32'h0, 32'h0);
    issue_request(OP_NONE, $urandom, $urandom);
    issue_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_REMOVE, 32'd100, 32'h0);
    issue_request(OP_REMOVE, 32'd100, 32'h0);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    hold_until_drained();

    // Random: alternating fill and drain segments under each idle mix
    for (seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 45; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      filling = (seg % 2 == 0);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        roll = $urandom_range(99);
        if (filling)
          op = (roll < 82) ? OP_INSERT : (roll < 92) ? OP_LOOKUP :
               (roll < 97) ? OP_REMOVE : OP_NONE;
        else
          op = (roll < 8) ? OP_INSERT : (roll < 20) ? OP_LOOKUP :
               (roll < 97) ? OP_REMOVE : OP_NONE;
        k = pick_key();
        case (op)
          OP_INSERT: key_log.push_back(k);
          OP_REMOVE: begin
            if (key_log.size() > 0 && $urandom_range(99) < 85) begin
              pos = $urandom_range(key_log.size() - 1);
              k = key_log[pos];
              key_log.delete(pos);
            end
          end
          OP_LOOKUP: begin
            if (key_log.size() > 0 && $urandom_range(1) == 1)
              k = key_log[$urandom_range(key_log.size() - 1)];
          end
          default: k = $urandom;
        endcase
        issue_request(op, k, $urandom);
        if (op != OP_NONE) sent++;
      end
      hold_until_drained();
    end

    // Let any stray result surface before the verdict
    gap_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d lookups, %0d inserts, %0d removes and %0d unused opcodes",
             n_lookup, n_insert, n_remove, n_none);
    $display("Checked %0d results over fill and drain phases with four idle/stall mixes",
             checked);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/skc_pkg.sv
sv/skc_store.sv
sv/sorted_key_container_top.sv
tb/sorted_key_container_checker.sv
tb/tb.sv
